[design/assert_macros.svh]
// Assertion macros shared by the hold-back queue RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies c in the same cycle, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// a implies c in the next cycle, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

[design/tohbq_pkg.sv]
// Types and codes of the total-order hold-back queue.
// No dependencies; used by the cell and the top level.
`default_nettype none

package tohbq_pkg;

    // index fields are sized for the largest supported queue depth
    localparam int IDX_W = 8;

    typedef enum logic [2:0] {
        KIND_ACK     = 3'd0,
        KIND_SEQ_ACK = 3'd1,
        KIND_DELIVER = 3'd2,
        KIND_DROP    = 3'd3,
        KIND_FULL    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MIN
    } t_state;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_FINAL,
        WR_CLEAR
    } t_wr_op;

    typedef struct packed {
        logic        mode;
        logic [3:0]  sender;
        logic [31:0] msg_id;
        logic [31:0] payload;
        logic [31:0] agreed_seq;
        logic [3:0]  final_proposer;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  out_sender;
        logic [31:0] out_msg_id;
        logic [31:0] out_seq;
        logic [3:0]  out_proposer;
        logic [31:0] out_data;
        logic        last;
    } t_out;

    // broadcast write to one cell
    typedef struct packed {
        t_wr_op           op;
        logic [IDX_W-1:0] idx;
        logic [31:0]      seq;
        logic [31:0]      msg_id;
        logic [3:0]       sender;
        logic [3:0]       proposer;
        logic [31:0]      data;
    } t_wr;

    // search token passed down the chain
    typedef struct packed {
        logic             valid;
        logic             m_found;
        logic [IDX_W-1:0] m_idx;
        logic [31:0]      m_seq;
        logic [3:0]       m_prop;
        logic             f_found;
        logic [IDX_W-1:0] f_idx;
        logic             n_found;
        logic [IDX_W-1:0] n_idx;
        logic             n_deliv;
        logic [31:0]      n_seq;
        logic [3:0]       n_sender;
        logic [31:0]      n_msg_id;
        logic [3:0]       n_prop;
        logic [31:0]      n_data;
    } t_tok;

endpackage

`default_nettype wire

[design/tohbq_cell.sv]
// One hold-back queue entry and its stage of the search chain.
// Depends on tohbq_pkg.
`default_nettype none

module tohbq_cell #(
    parameter int INDEX = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tohbq_pkg::t_wr  i_wr,
    input  wire logic [3:0]      i_key_sender,
    input  wire logic [31:0]     i_key_id,
    input  wire tohbq_pkg::t_tok i_tok,
    output tohbq_pkg::t_tok      o_tok
);

    logic        r_valid, r_deliv;
    logic [31:0] r_seq, r_msg_id, r_data;
    logic [3:0]  r_sender, r_prop;
    tohbq_pkg::t_tok r_tok, n_tok;

    localparam logic [tohbq_pkg::IDX_W-1:0] MY_IDX = tohbq_pkg::IDX_W'(INDEX);

    logic sel, pend, earlier;

    assign sel  = (i_wr.idx == MY_IDX);
    assign pend = r_valid && !r_deliv && (r_sender == i_key_sender) && (r_msg_id == i_key_id);

    // strict order: seq, undeliverable first, sender, msg id
    always_comb begin
        if (r_seq != i_tok.n_seq) begin
            earlier = (r_seq < i_tok.n_seq);
        end else if (r_deliv != i_tok.n_deliv) begin
            earlier = !r_deliv;
        end else if (r_sender != i_tok.n_sender) begin
            earlier = (r_sender < i_tok.n_sender);
        end else begin
            earlier = (r_msg_id < i_tok.n_msg_id);
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            if (!i_tok.m_found && pend) begin
                n_tok.m_found = 1'b1;
                n_tok.m_idx   = MY_IDX;
                n_tok.m_seq   = r_seq;
                n_tok.m_prop  = r_prop;
            end
            if (!i_tok.f_found && !r_valid) begin
                n_tok.f_found = 1'b1;
                n_tok.f_idx   = MY_IDX;
            end
            if (r_valid && (!i_tok.n_found || earlier)) begin
                n_tok.n_found  = 1'b1;
                n_tok.n_idx    = MY_IDX;
                n_tok.n_deliv  = r_deliv;
                n_tok.n_seq    = r_seq;
                n_tok.n_sender = r_sender;
                n_tok.n_msg_id = r_msg_id;
                n_tok.n_prop   = r_prop;
                n_tok.n_data   = r_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_valid <= 1'b0;
            r_deliv <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (sel) begin
                unique case (i_wr.op)
                    tohbq_pkg::WR_NEW: begin
                        r_valid <= 1'b1;
                        r_deliv <= 1'b0;
                    end
                    tohbq_pkg::WR_FINAL: begin
                        r_deliv <= 1'b1;
                    end
                    tohbq_pkg::WR_CLEAR: begin
                        r_valid <= 1'b0;
                        r_deliv <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // entry contents, no reset
    always_ff @(posedge i_clk) begin
        if (sel && i_wr.op == tohbq_pkg::WR_NEW) begin
            r_seq    <= i_wr.seq;
            r_msg_id <= i_wr.msg_id;
            r_sender <= i_wr.sender;
            r_prop   <= i_wr.proposer;
            r_data   <= i_wr.data;
        end else if (sel && i_wr.op == tohbq_pkg::WR_FINAL) begin
            r_seq  <= i_wr.seq;
            r_prop <= i_wr.proposer;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

[design/total_order_hold_back_queue_top.sv]
// Top level of the total-order hold-back queue: control sequencer and cell chain.
// Depends on tohbq_pkg, tohbq_cell and assert_macros.svh.
`default_nettype none

// Receiver side of a total-order multicast group. Raise start with an item
// while busy is low; results come back one per strobe on o_valid and cannot
// be held off, so the receiver must take each one in the cycle it appears.
// The last result of an item has last set. Every lookup is a token that
// walks the chain of QUEUE_DEPTH cells, one cell a cycle, so a data message
// or an unknown sequence message walks the chain once; an invalid message
// walks no chain, never raises busy and gives its result in the cycle after
// it is taken. A sequence message that makes entries deliverable takes the
// lookup walk, one chain walk per delivery, plus one walk that finds nothing
// more to deliver. Configuration (own id, group size) must be written by the
// user only while busy is low; the block itself does not enforce this. The
// queue needs no clearing pass after reset.
module total_order_hold_back_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire tohbq_pkg::t_in i_in,
    output logic                o_valid,
    output tohbq_pkg::t_out     o_out,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_idx,
    input  wire logic [4:0]     i_cfg_data
);

    localparam logic REG_OWN_ID = 1'b0;

    tohbq_pkg::t_state r_state, n_state;
    tohbq_pkg::t_in    r_in, n_in;
    tohbq_pkg::t_out   r_out, n_out, r_hold, n_hold;
    logic              r_valid, n_valid;
    logic              r_launch, n_launch;
    logic [31:0]       r_cnt, n_cnt;
    logic [3:0]        r_own;
    logic [4:0]        r_pcount;
    tohbq_pkg::t_wr    wr;
    tohbq_pkg::t_tok   tok [QUEUE_DEPTH+1];
    tohbq_pkg::t_tok   tok_out;
    logic              bad;

    function automatic tohbq_pkg::t_out mk(tohbq_pkg::t_kind k, logic [3:0] s,
                                           logic [31:0] id, logic [31:0] sq,
                                           logic [3:0] p, logic [31:0] d, logic l);
        tohbq_pkg::t_out o;
        o.kind         = k;
        o.out_sender   = s;
        o.out_msg_id   = id;
        o.out_seq      = sq;
        o.out_proposer = p;
        o.out_data     = d;
        o.last         = l;
        return o;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own    <= 4'd0;
            r_pcount <= 5'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_OWN_ID) begin
                r_own <= i_cfg_data[3:0];
            end else begin
                r_pcount <= i_cfg_data;
            end
        end
    end

    // chain: token enters cell 0 and is registered in each cell in turn before it leaves the last cell
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = r_launch;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tohbq_cell #(.INDEX(g)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr         (wr),
            .i_key_sender (r_in.sender),
            .i_key_id     (r_in.msg_id),
            .i_tok        (tok[g]),
            .o_tok        (tok[g+1])
        );
    end

    assign tok_out = tok[QUEUE_DEPTH];

    // sender check, and proposer check for a sequence message
    assign bad = ({1'b0, i_in.sender} >= r_pcount) ||
                 (i_in.mode && ({1'b0, i_in.final_proposer} >= r_pcount));

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_out    = r_out;
        n_hold   = r_hold;
        n_valid  = 1'b0;
        n_launch = 1'b0;
        n_cnt    = r_cnt;
        wr       = '0;
        wr.op    = tohbq_pkg::WR_NONE;
        unique case (r_state)
            tohbq_pkg::S_IDLE: begin
                if (start) begin
                    n_in = i_in;
                    if (bad) begin
                        n_out   = mk(tohbq_pkg::KIND_DROP, i_in.sender, i_in.msg_id,
                                     32'd0, 4'd0, 32'd0, 1'b1);
                        n_valid = 1'b1;
                    end else begin
                        n_launch = 1'b1;
                        n_state  = tohbq_pkg::S_SCAN;
                    end
                end
            end
            tohbq_pkg::S_SCAN: begin
                if (tok_out.valid) begin
                    n_valid = 1'b1;
                    n_state = tohbq_pkg::S_IDLE;
                    if (!r_in.mode) begin
                        if (tok_out.m_found) begin
                            n_out = mk(tohbq_pkg::KIND_ACK, r_in.sender, r_in.msg_id,
                                       tok_out.m_seq, tok_out.m_prop, 32'd0, 1'b1);
                        end else if (tok_out.f_found) begin
                            n_cnt       = r_cnt + 32'd1;
                            wr.op       = tohbq_pkg::WR_NEW;
                            wr.idx      = tok_out.f_idx;
                            wr.seq      = n_cnt;
                            wr.msg_id   = r_in.msg_id;
                            wr.sender   = r_in.sender;
                            wr.proposer = r_own;
                            wr.data     = r_in.payload;
                            n_out = mk(tohbq_pkg::KIND_ACK, r_in.sender, r_in.msg_id,
                                       n_cnt, r_own, 32'd0, 1'b1);
                        end else begin
                            n_out = mk(tohbq_pkg::KIND_FULL, r_in.sender, r_in.msg_id,
                                       32'd0, 4'd0, 32'd0, 1'b1);
                        end
                    end else begin
                        if (r_in.agreed_seq > r_cnt) begin
                            n_cnt = r_in.agreed_seq;
                        end
                        if (tok_out.m_found) begin
                            // ack waits in the hold register until we know whether it is last
                            n_valid     = 1'b0;
                            wr.op       = tohbq_pkg::WR_FINAL;
                            wr.idx      = tok_out.m_idx;
                            wr.seq      = r_in.agreed_seq;
                            wr.proposer = r_in.final_proposer;
                            n_hold = mk(tohbq_pkg::KIND_SEQ_ACK, r_in.sender, r_in.msg_id,
                                        32'd0, 4'd0, 32'd0, 1'b0);
                            n_launch = 1'b1;
                            n_state  = tohbq_pkg::S_MIN;
                        end else begin
                            n_out = mk(tohbq_pkg::KIND_SEQ_ACK, r_in.sender, r_in.msg_id,
                                       32'd0, 4'd0, 32'd0, 1'b1);
                        end
                    end
                end
            end
            tohbq_pkg::S_MIN: begin
                if (tok_out.valid) begin
                    n_valid = 1'b1;
                    n_out   = r_hold;
                    if (tok_out.n_found && tok_out.n_deliv) begin
                        wr.op    = tohbq_pkg::WR_CLEAR;
                        wr.idx   = tok_out.n_idx;
                        n_hold   = mk(tohbq_pkg::KIND_DELIVER, tok_out.n_sender,
                                      tok_out.n_msg_id, tok_out.n_seq, tok_out.n_prop,
                                      tok_out.n_data, 1'b0);
                        n_launch = 1'b1;
                    end else begin
                        n_out.last = 1'b1;
                        n_state    = tohbq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = tohbq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tohbq_pkg::S_IDLE;
            r_valid  <= 1'b0;
            r_launch <= 1'b0;
            r_cnt    <= 32'd0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_launch <= n_launch;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign busy    = (r_state != tohbq_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_tok_in_search, i_clk, i_rst_n, tok_out.valid,
        r_state == tohbq_pkg::S_SCAN || r_state == tohbq_pkg::S_MIN)
    `ASSERT_NEXT(a_launch_busy, i_clk, i_rst_n, n_launch, busy)
    `ASSERT_IMPLIES(a_deliver_in_min, i_clk, i_rst_n,
        r_valid && r_out.kind == tohbq_pkg::KIND_DELIVER,
        r_state == tohbq_pkg::S_MIN || r_state == tohbq_pkg::S_IDLE)

endmodule

`default_nettype wire

[sim/total_order_hold_back_queue_top_tb.sv]
// Testbench of the total-order hold-back queue: directed and random messages.
// A scoreboard class predicts acks and deliveries; depends on tohbq_pkg and the top level.
`timescale 1ns / 100ps

module total_order_hold_back_queue_top_tb;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic CFG_OWN_ID = 1'b0;
    localparam logic CFG_PROC_COUNT = 1'b1;
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_FINAL = 1'b1;

    // Hold-back table model plus the queue of results not yet seen.
    class hold_back_board;
        logic [3:0]  own_id;
        logic [4:0]  proc_count;
        logic [31:0] seq_ctr;
        bit          ent_valid [DEPTH];
        bit          ent_deliv [DEPTH];
        logic [31:0] ent_seq [DEPTH];
        logic [31:0] ent_id [DEPTH];
        logic [3:0]  ent_snd [DEPTH];
        logic [3:0]  ent_prop [DEPTH];
        logic [31:0] ent_data [DEPTH];
        tohbq_pkg::t_out pending_results [$];
        int          errors;

        function new();
            own_id = 0;
            proc_count = 1;
            seq_ctr = 0;
            errors = 0;
            foreach (ent_valid[i]) begin
                ent_valid[i] = 0;
                ent_deliv[i] = 0;
            end
        endfunction

        function void push(tohbq_pkg::t_kind k, logic [3:0] s, logic [31:0] id,
                           logic [31:0] sq, logic [3:0] p, logic [31:0] d);
            tohbq_pkg::t_out r;
            r.kind = k;
            r.out_sender = s;
            r.out_msg_id = id;
            r.out_seq = sq;
            r.out_proposer = p;
            r.out_data = d;
            r.last = 0;
            pending_results.push_back(r);
        endfunction

        function int find_held(logic [3:0] s, logic [31:0] id);
            for (int i = 0; i < DEPTH; i++)
                if (ent_valid[i] && !ent_deliv[i] && ent_snd[i] == s && ent_id[i] == id)
                    return i;
            return -1;
        endfunction

        function bit sorts_first(int a, int b);
            if (ent_seq[a] != ent_seq[b]) return ent_seq[a] < ent_seq[b];
            if (ent_deliv[a] != ent_deliv[b]) return !ent_deliv[a];
            if (ent_snd[a] != ent_snd[b]) return ent_snd[a] < ent_snd[b];
            return ent_id[a] < ent_id[b];
        endfunction

        function void note_item(tohbq_pkg::t_in it);
            int e;
            int fr;
            int m;
            e = find_held(it.sender, it.msg_id);
            if (it.mode == MODE_DATA) begin
                if (5'(it.sender) >= proc_count) begin
                    push(tohbq_pkg::KIND_DROP, it.sender, it.msg_id, 32'd0, 4'd0, 32'd0);
                end else if (e >= 0) begin
                    push(tohbq_pkg::KIND_ACK, it.sender, it.msg_id, ent_seq[e], ent_prop[e],
                         32'd0);
                end else begin
                    fr = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (fr < 0 && !ent_valid[i]) fr = i;
                    if (fr < 0) begin
                        push(tohbq_pkg::KIND_FULL, it.sender, it.msg_id, 32'd0, 4'd0, 32'd0);
                    end else begin
                        seq_ctr = seq_ctr + 32'd1;
                        ent_valid[fr] = 1;
                        ent_deliv[fr] = 0;
                        ent_seq[fr] = seq_ctr;
                        ent_id[fr] = it.msg_id;
                        ent_snd[fr] = it.sender;
                        ent_prop[fr] = own_id;
                        ent_data[fr] = it.payload;
                        push(tohbq_pkg::KIND_ACK, it.sender, it.msg_id, seq_ctr, own_id, 32'd0);
                    end
                end
            end else if (5'(it.sender) >= proc_count ||
                         5'(it.final_proposer) >= proc_count) begin
                push(tohbq_pkg::KIND_DROP, it.sender, it.msg_id, 32'd0, 4'd0, 32'd0);
            end else begin
                if (it.agreed_seq > seq_ctr) seq_ctr = it.agreed_seq;
                push(tohbq_pkg::KIND_SEQ_ACK, it.sender, it.msg_id, 32'd0, 4'd0, 32'd0);
                if (e >= 0) begin
                    ent_seq[e] = it.agreed_seq;
                    ent_prop[e] = it.final_proposer;
                    ent_deliv[e] = 1;
                    forever begin
                        m = -1;
                        for (int i = 0; i < DEPTH; i++)
                            if (ent_valid[i] && (m < 0 || sorts_first(i, m))) m = i;
                        if (m < 0 || !ent_deliv[m]) break;
                        push(tohbq_pkg::KIND_DELIVER, ent_snd[m], ent_id[m], ent_seq[m],
                             ent_prop[m], ent_data[m]);
                        ent_valid[m] = 0;
                        ent_deliv[m] = 0;
                    end
                end
            end
            pending_results[$].last = 1;
        endfunction

        function void check_result(tohbq_pkg::t_out act);
            tohbq_pkg::t_out exp;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, act);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (act.kind !== exp.kind || act.out_sender !== exp.out_sender ||
                act.out_msg_id !== exp.out_msg_id || act.out_seq !== exp.out_seq ||
                act.out_proposer !== exp.out_proposer || act.out_data !== exp.out_data ||
                act.last !== exp.last) begin
                $display("%0t: mismatch expected %h actual %h", $time, exp, act);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            start = 0;
    logic            busy;
    tohbq_pkg::t_in  i_in = '0;
    logic            o_valid;
    tohbq_pkg::t_out o_out;
    logic            i_cfg_we = 0;
    logic            i_cfg_idx = 0;
    logic [4:0]      i_cfg_data = 0;

    hold_back_board board = new();
    int cycles = 0;

    // recent ids, so final messages mostly hit held entries
    logic [3:0]  recent_snd [$];
    logic [31:0] recent_id [$];

    total_order_hold_back_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Results cannot be held off: sample every strobe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_out);
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_cfg(logic idx, logic [4:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_OWN_ID) board.own_id = val[3:0];
        else board.proc_count = val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // Present one item and hold it until taken; start drops for a cycle
    // before the next item.
    task automatic send_item(tohbq_pkg::t_in it);
        start <= 1;
        i_in <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(it);
        start <= 0;
        if (it.mode == MODE_DATA) begin
            recent_snd.push_back(it.sender);
            recent_id.push_back(it.msg_id);
            if (recent_snd.size() > 24) begin
                void'(recent_snd.pop_front());
                void'(recent_id.pop_front());
            end
        end
        @(posedge i_clk);
    endtask

    // Idle point for config writes: results drained, then the chain settles.
    task automatic drain();
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (3 * DEPTH + 8) @(posedge i_clk);
    endtask

    function automatic tohbq_pkg::t_in make_item(logic m, logic [3:0] s, logic [31:0] id,
                                                 logic [31:0] d, logic [31:0] fs,
                                                 logic [3:0] fp);
        tohbq_pkg::t_in it;
        it.mode = m;
        it.sender = s;
        it.msg_id = id;
        it.payload = d;
        it.agreed_seq = fs;
        it.final_proposer = fp;
        return it;
    endfunction

    // Mostly valid messages on a small id space so lookups hit; some noise.
    function automatic tohbq_pkg::t_in rand_item(int pc);
        tohbq_pkg::t_in it;
        int pick;
        it = make_item(1'($urandom_range(0, 1)), 4'($urandom), $urandom, $urandom,
                       $urandom, 4'($urandom));
        pick = int'($urandom_range(0, 99));
        if (pick < 85) it.sender = 4'($urandom_range(0, pc - 1));
        if (pick < 85) it.final_proposer = 4'($urandom_range(0, pc - 1));
        if (pick < 60) it.msg_id = 32'($urandom_range(0, 7) | ($urandom_range(0, 1) << 31));
        if (it.mode == MODE_FINAL && pick < 70 && recent_snd.size() > 0) begin
            int k = int'($urandom_range(0, recent_snd.size() - 1));
            it.sender = recent_snd[k];
            it.msg_id = recent_id[k];
            if ($urandom_range(0, 3) != 0)
                it.agreed_seq = board.seq_ctr + 32'($urandom_range(0, 5));
        end
        return it;
    endfunction

    initial begin
        int pc;
        int burst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: invalid sender at reset group size, then extremes
        send_item(make_item(MODE_DATA, 4'd1, 32'd5, 32'd1, 32'd0, 4'd0));
        write_cfg(CFG_OWN_ID, 5'd15);
        write_cfg(CFG_PROC_COUNT, 5'd16);
        send_item(make_item(MODE_DATA, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 4'd0));
        send_item(make_item(MODE_DATA, 4'd15, 32'hFFFF_FFFF, 32'h0, 32'd0, 4'd0));  // repeat ack
        send_item(make_item(MODE_DATA, 4'd0, 32'd0, 32'hA5A5_5A5A, 32'd0, 4'd0));
        // final for unknown message: counter forwarded, no delivery
        send_item(make_item(MODE_FINAL, 4'd3, 32'd77, 32'd0, 32'd10, 4'd2));
        // re-key second entry to come after the first: nothing yet
        send_item(make_item(MODE_FINAL, 4'd0, 32'd0, 32'd0, 32'd20, 4'd15));
        // first entry final with the same seq from proposer 0: delivers both, lower sender first
        send_item(make_item(MODE_FINAL, 4'd15, 32'hFFFF_FFFF, 32'd0, 32'd20, 4'd0));
        // counter wrap: raise to max, then new data wraps to 0
        send_item(make_item(MODE_FINAL, 4'd2, 32'd9, 32'd0, 32'hFFFF_FFFF, 4'd1));
        send_item(make_item(MODE_DATA, 4'd2, 32'd9, 32'd9, 32'd0, 4'd0));
        send_item(make_item(MODE_FINAL, 4'd2, 32'd9, 32'd0, 32'hFFFF_FFFF, 4'd1));
        // invalid final proposer, then invalid sender, with small group
        drain();
        write_cfg(CFG_PROC_COUNT, 5'd2);
        write_cfg(CFG_OWN_ID, 5'd0);
        send_item(make_item(MODE_FINAL, 4'd0, 32'd1, 32'd0, 32'd1, 4'd5));
        send_item(make_item(MODE_FINAL, 4'd5, 32'd1, 32'd0, 32'd1, 4'd0));
        // fill the table, then overflow
        for (int i = 0; i < DEPTH + 1; i++)
            send_item(make_item(MODE_DATA, 4'(i % 2), 32'(100 + i), $urandom, 32'd0, 4'd0));
        // final each held entry in turn with seq 0: each is delivered at once
        for (int i = 0; i < DEPTH; i++)
            send_item(make_item(MODE_FINAL, 4'(i % 2), 32'(100 + i), 32'd0, 32'd0, 4'd1));

        // random phases with varied config
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            pc = (ph == 0) ? 1 : (ph == 1) ? 16 : int'($urandom_range(1, 16));
            write_cfg(CFG_PROC_COUNT, 5'(pc));
            write_cfg(CFG_OWN_ID, 5'($urandom_range(0, 15)));
            for (int n = 0; n < 85;) begin
                burst = int'($urandom_range(1, 8));
                for (int b = 0; b < burst && n < 85; b++, n++) send_item(rand_item(pc));
                if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (3 * DEPTH + 8) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/tohbq_pkg.sv
design/tohbq_cell.sv
design/total_order_hold_back_queue_top.sv
sim/total_order_hold_back_queue_top_tb.sv
